### sv/call_stack_sample_dedup_buffer_macros.svh
// assertion macros for the call stack sample buffer checker
`ifndef CALL_STACK_SAMPLE_DEDUP_BUFFER_MACROS_SVH
`define CALL_STACK_SAMPLE_DEDUP_BUFFER_MACROS_SVH
// assert that an antecedent implies a consequent in the same cycle
`define CSSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// assert that an antecedent implies a consequent in the next cycle
`define CSSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### sv/cssd_pkg.sv
// shared types and constants for the call stack sample buffer
package cssd_pkg;
  localparam int BUFFER_ENTRIES   = 1024;
  localparam int MAX_STACK_FRAMES = 100;
  localparam int STACK_LIMIT = (MAX_STACK_FRAMES < BUFFER_ENTRIES) ?
                               MAX_STACK_FRAMES : BUFFER_ENTRIES;
  localparam int BUF_AW   = $clog2(BUFFER_ENTRIES);
  localparam int FILL_W   = $clog2(BUFFER_ENTRIES + 1);
  localparam int STK_AW   = $clog2(STACK_LIMIT);
  localparam int DEPTH_W  = $clog2(STACK_LIMIT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = 1;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [2:0] ST_FRAME   = 3'd0;
  localparam logic [2:0] ST_MATCH   = 3'd1;
  localparam logic [2:0] ST_APPEND  = 3'd2;
  localparam logic [2:0] ST_FLUSH   = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  localparam logic [7:0] COUNT_SAT = 8'd255;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] frame_addr;
    logic        last_frame;
    logic [9:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  result_index;
    logic [63:0] entry_addr;
    logic [7:0]  entry_count;
    logic [10:0] fill_length;
    logic [63:0] addr_low;
    logic [63:0] addr_high;
    logic        truncated;
  } out_item_t;

  // one command from front to back
  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] frame_addr;
    logic        last_frame;
    logic [9:0]  entry_index;
  } cmd_t;
endpackage

### sv/cssd_front.sv
// front end: takes commands and queues them for the engine
module cssd_front
  import cssd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);
  cmd_t               q_mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;
  logic                push;

  // action three is dropped here and never reaches the engine
  assign busy      = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push      = start && !busy && (in_item.action != ACT_NONE);
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(cmd_take && cmd_valid)) cnt_nxt = cnt_r + 1'b1;
    else if (!push && cmd_take && cmd_valid) cnt_nxt = cnt_r - 1'b1;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r].action      <= in_item.action;
      q_mem_r[wr_ptr_r].frame_addr  <= in_item.frame_addr;
      q_mem_r[wr_ptr_r].last_frame  <= in_item.last_frame;
      q_mem_r[wr_ptr_r].entry_index <= in_item.entry_index;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (cmd_take && cmd_valid) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

### sv/cssd_engine.sv
// back end: stack collection, buffer search, append, read and clear
module cssd_engine
  import cssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      out_valid,
  output out_item_t out_item
);
  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_SCAN   = 8'b00000010,
    S_CMP    = 8'b00000100,
    S_BUMP   = 8'b00001000,
    S_APPEND = 8'b00010000,
    S_READ   = 8'b00100000,
    S_RDOUT  = 8'b01000000,
    S_WIPE   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [63:0] stk_mem  [STACK_LIMIT];
  logic [63:0] addr_mem [BUFFER_ENTRIES];
  logic [7:0]  cnt_mem  [BUFFER_ENTRIES];

  logic [DEPTH_W-1:0] depth_r;
  logic               cut_r, held_r;
  logic [FILL_W-1:0]  fill_r;
  logic [63:0]        lo_r, hi_r;
  cmd_t               cur_r;

  // search registers
  logic [FILL_W-1:0]  cand_r;   // candidate start position
  logic [DEPTH_W-1:0] j_r;      // frame within stack
  logic               found_r;
  logic [BUF_AW-1:0]  hit_r;
  logic [7:0]         hit_cnt_r;
  logic [7:0]         cand_cnt_r; // count at the candidate under compare
  logic               wait_r;   // memory read in flight
  logic [63:0]        rd_addr_r, stk_rd_r;
  logic [7:0]         rd_cnt_r;
  logic               from_clear_r;
  logic [FILL_W-1:0]  start_r;

  logic [BUF_AW-1:0]  ra;
  logic [STK_AW-1:0]  sa;
  logic               wr_en;
  logic               wr_addr_en;
  logic [BUF_AW-1:0]  wa;
  logic [63:0]        wd;
  logic [7:0]         wc;
  logic [FILL_W-1:0]  pos;

  // buffer read/write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wa]  <= wc;
    end
    if (wr_addr_en) begin
      addr_mem[wa] <= wd;
    end
    rd_addr_r <= addr_mem[ra];
    rd_cnt_r  <= cnt_mem[ra];
    stk_rd_r  <= stk_mem[sa];
  end

  // stack store write
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_valid && cmd.action == ACT_PUSH && !held_r &&
        depth_r < DEPTH_W'(STACK_LIMIT))
      stk_mem[depth_r[STK_AW-1:0]] <= cmd.frame_addr;
  end

  assign pos = cand_r + FILL_W'(j_r);

  // address selection and writes
  always_comb begin
    ra         = cand_r[BUF_AW-1:0];
    sa         = j_r[STK_AW-1:0];
    wr_en      = 1'b0;
    wr_addr_en = 1'b0;
    wa         = hit_r;
    wd         = rd_addr_r;
    wc         = hit_cnt_r + 8'd1;
    unique case (state_r)
      S_SCAN:   ra = cand_r[BUF_AW-1:0];
      S_CMP:    ra = pos[BUF_AW-1:0];
      S_BUMP:   wr_en = 1'b1;
      S_APPEND: begin
        wr_en      = wait_r;
        wr_addr_en = wait_r;
        wa         = fill_r[BUF_AW-1:0];
        wd         = stk_rd_r;
        wc         = (j_r == DEPTH_W'(1)) ? 8'd1 : 8'd0;
      end
      S_READ:   ra = cur_r.entry_index[BUF_AW-1:0];
      default:  ;
    endcase
  end

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;

  logic [DEPTH_W-1:0] depth_new;
  logic               cut_new;

  // stack depth and cut flag after one more pushed frame
  always_comb begin
    depth_new = depth_r;
    cut_new   = cut_r;
    if (depth_r < DEPTH_W'(STACK_LIMIT)) depth_new = depth_r + 1'b1;
    else cut_new = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      depth_r   <= '0;
      cut_r     <= 1'b0;
      held_r    <= 1'b0;
      fill_r    <= '0;
      lo_r      <= '1;
      hi_r      <= '0;
      out_valid <= 1'b0;
      wait_r    <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (cmd_valid) begin
          cur_r <= cmd;
          out_item.entry_addr  <= '0;
          out_item.entry_count <= '0;
          out_item.truncated   <= 1'b0;
          if (cmd.action == ACT_PUSH) begin
            if (held_r) begin
              out_item.status       <= ST_FLUSH;
              out_item.result_index <= '0;
              out_item.truncated    <= cut_r;
              out_item.fill_length  <= fill_r;
              out_item.addr_low     <= lo_r;
              out_item.addr_high    <= hi_r;
              out_valid <= 1'b1;
            end else begin
              depth_r <= depth_new;
              cut_r   <= cut_new;
              out_item.truncated <= cut_new;
              if (!cmd.last_frame) begin
                out_item.status       <= ST_FRAME;
                out_item.result_index <= 10'(depth_new);
                out_item.fill_length  <= fill_r;
                out_item.addr_low     <= lo_r;
                out_item.addr_high    <= hi_r;
                out_valid <= 1'b1;
              end else begin
                cand_r  <= '0;
                found_r <= 1'b0;
                wait_r  <= 1'b0;
                state_r <= S_SCAN;
              end
            end
          end else if (cmd.action == ACT_READ) begin
            state_r <= S_READ;
          end else begin
            // clear: empty buffer, then append a held stack
            fill_r <= '0;
            lo_r   <= '1;
            hi_r   <= '0;
            cand_r <= '0;
            state_r <= S_WIPE;
          end
        end
        S_SCAN: begin
          // fetch count at candidate
          if (cand_r >= fill_r) begin
            if (found_r) begin
              state_r <= S_BUMP;
            end else if (32'(fill_r) + 32'(depth_r) > BUFFER_ENTRIES) begin
              held_r <= 1'b1;
              out_item.status       <= ST_FLUSH;
              out_item.result_index <= '0;
              out_item.fill_length  <= fill_r;
              out_item.addr_low     <= lo_r;
              out_item.addr_high    <= hi_r;
              out_valid <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              from_clear_r <= 1'b0;
              start_r <= fill_r;
              j_r     <= '0;
              wait_r  <= 1'b0;
              state_r <= S_APPEND;
            end
          end else if (!wait_r) begin
            wait_r <= 1'b1;
          end else begin
            wait_r <= 1'b0;
            if (rd_cnt_r == 8'd0 || rd_cnt_r == COUNT_SAT) cand_r <= cand_r + 1'b1;
            else begin
              cand_cnt_r <= rd_cnt_r;
              j_r <= '0;
              state_r <= S_CMP;
            end
          end
        end
        S_CMP: begin
          // compare frame j at cand+j
          if (j_r == depth_r) begin
            found_r   <= 1'b1;
            hit_r     <= cand_r[BUF_AW-1:0];
            hit_cnt_r <= cand_cnt_r;
            state_r   <= S_SCAN;
            cand_r    <= cand_r + 1'b1;
          end else if (pos >= fill_r) begin
            state_r <= S_SCAN;
            cand_r  <= cand_r + 1'b1;
          end else if (!wait_r) begin
            wait_r <= 1'b1;
          end else begin
            wait_r <= 1'b0;
            if (rd_addr_r != stk_rd_r) begin
              state_r <= S_SCAN;
              cand_r  <= cand_r + 1'b1;
            end else j_r <= j_r + 1'b1;
          end
        end
        S_BUMP: begin
          out_item.status       <= ST_MATCH;
          out_item.result_index <= 10'(hit_r);
          out_item.fill_length  <= fill_r;
          out_item.addr_low     <= lo_r;
          out_item.addr_high    <= hi_r;
          out_valid <= 1'b1;
          depth_r <= '0;
          cut_r   <= 1'b0;
          state_r <= S_IDLE;
        end
        S_APPEND: begin
          // read a frame from the stack store, then write it to the buffer in the next cycle
          if (!wait_r) begin
            if (j_r == depth_r) begin
              out_item.status       <= from_clear_r ? ST_CLEARED : ST_APPEND;
              out_item.result_index <= 10'(start_r);
              out_item.truncated    <= cut_r;
              out_item.fill_length  <= fill_r;
              out_item.addr_low     <= lo_r;
              out_item.addr_high    <= hi_r;
              out_valid <= 1'b1;
              depth_r <= '0;
              cut_r   <= 1'b0;
              held_r  <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              wait_r <= 1'b1;
              j_r    <= j_r + 1'b1;
            end
          end else begin
            wait_r <= 1'b0;
            fill_r <= fill_r + 1'b1;
            if (stk_rd_r < lo_r) lo_r <= stk_rd_r;
            if (stk_rd_r > hi_r) hi_r <= stk_rd_r;
          end
        end
        S_READ: state_r <= S_RDOUT;
        S_RDOUT: begin
          out_item.status       <= ST_READ;
          out_item.result_index <= cur_r.entry_index;
          out_item.entry_addr   <= 64'(cur_r.entry_index) < 64'(fill_r) ? rd_addr_r : '0;
          out_item.entry_count  <= 64'(cur_r.entry_index) < 64'(fill_r) ? rd_cnt_r : '0;
          out_item.fill_length  <= fill_r;
          out_item.addr_low     <= lo_r;
          out_item.addr_high    <= hi_r;
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        S_WIPE: begin
          if (held_r) begin
            from_clear_r <= 1'b1;
            start_r <= '0;
            j_r     <= '0;
            wait_r  <= 1'b0;
            state_r <= S_APPEND;
          end else begin
            out_item.status       <= ST_CLEARED;
            out_item.result_index <= '0;
            out_item.fill_length  <= '0;
            out_item.addr_low     <= lo_r;
            out_item.addr_high    <= hi_r;
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/call_stack_sample_dedup_buffer.sv
// top level of the call stack sample buffer
// Each transaction is one action: push a frame, read an entry or clear.
// A push that is not the last frame is answered straight from idle. The last
// frame walks the buffer, comparing the stack at each position, then appends
// the stack if it matched nowhere and fits, so the time grows with fill
// length times matched prefix length. A clear also appends a held stack.
// Positions beyond the fill length read as zero, so a clear needs no sweep of
// the buffer. Results are strobed for one cycle on out_valid and cannot be
// held off; a two-entry command queue keeps start/busy apart from the engine.
module call_stack_sample_dedup_buffer
  import cssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  cssd_front u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .cmd_valid, .cmd, .cmd_take
  );

  cssd_engine u_engine (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .out_valid, .out_item
  );
endmodule

### sv/cssd_checker.sv
// port level checker for the call stack sample buffer
`include "call_stack_sample_dedup_buffer_macros.svh"
module cssd_checker
  import cssd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input out_item_t out_item
);
  `CSSD_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_item.status <= ST_CLEARED, "bad status")
  `CSSD_ASSERT_IMP(a_fill_range, clk, rst_n, out_valid, out_item.fill_length <= 11'(BUFFER_ENTRIES), "fill too large")
  `CSSD_ASSERT_IMP(a_clear_empty, clk, rst_n, out_valid && out_item.status == ST_CLEARED && out_item.fill_length == '0, out_item.addr_high == '0, "range not reset")
  `CSSD_ASSERT_IMP(a_read_zero, clk, rst_n, out_valid && out_item.status != ST_READ, out_item.entry_count == '0, "count on non-read")
endmodule

bind call_stack_sample_dedup_buffer cssd_checker u_cssd_checker (.*);
